// File: rtl/ppd_pkg.sv
// Shared types, constants and helpers for the parking sensor pulse decoder.
`default_nettype none
package ppd_pkg;

    // Pulse width windows in timer ticks
    localparam int unsigned WIDTH_W  = 27;
    localparam logic [WIDTH_W-1:0] ZERO_MIN = 27'd36000;
    localparam logic [WIDTH_W-1:0] ZERO_MAX = 27'd156000;
    localparam logic [WIDTH_W-1:0] ONE_MIN  = 27'd160000;
    localparam logic [WIDTH_W-1:0] ONE_MAX  = 27'd800000;

    // Packet word layout
    localparam int unsigned PACKET_BITS = 24;
    localparam int unsigned COUNT_W     = 5;
    localparam logic [3:0]  ID_MASK     = 4'hf;
    localparam logic [7:0]  VAL_MASK    = 8'hff;

    // Head slot table
    localparam int unsigned NUM_SLOTS  = 4;
    localparam int unsigned SLOT_W     = 2;
    localparam int unsigned USED_W     = 3;
    localparam logic [7:0]  BUZZER_BIAS = 8'd240;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_SLOT0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_SLOT1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_SLOT2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_SLOT3 = 3'd4;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_CHECK_FAIL = 2'd1;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [3:0]                  line_id;
        logic [NUM_SLOTS-1:0][7:0]   shift;
    } ppd_cfg_t;

    // Queue status toward the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } ppd_q_stat_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_FINISH
    } ppd_bk_state_t;

    function automatic logic [3:0] rev4(input logic [3:0] v);
        logic [3:0] r;
        for (int i = 0; i < 4; i++) r[i] = v[3-i];
        return r;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[i] = v[7-i];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ppd_front.sv
// Front end: classify pulse pairs and collect bits into 24-bit packet words.
`default_nettype none
module ppd_front (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_accept,
    input  wire logic [26:0] low_width,
    input  wire logic [26:0] high_width,
    output logic             pkt_push,
    output logic [23:0]      pkt_word
);

    logic [ppd_pkg::COUNT_W-1:0]     bit_count_reg, bit_count_next;
    logic [ppd_pkg::PACKET_BITS-1:0] packet_bits_reg, packet_bits_next;
    logic is_zero, is_one, last_bit;
    logic [ppd_pkg::PACKET_BITS-1:0] word_with_bit;

    // Classify the pair against both windows
    always_comb begin
        is_zero = (low_width >= ppd_pkg::ZERO_MIN) && (low_width <= ppd_pkg::ZERO_MAX) &&
                  (high_width >= ppd_pkg::ZERO_MIN) && (high_width <= ppd_pkg::ZERO_MAX);
        is_one  = (low_width >= ppd_pkg::ONE_MIN) && (low_width <= ppd_pkg::ONE_MAX) &&
                  (high_width >= ppd_pkg::ONE_MIN) && (high_width <= ppd_pkg::ONE_MAX);
    end

    // Insert the new bit and detect the end of a packet
    always_comb begin
        word_with_bit = packet_bits_reg;
        if (is_one) word_with_bit[bit_count_reg] = 1'b1;
        last_bit = (bit_count_reg == ppd_pkg::COUNT_W'(ppd_pkg::PACKET_BITS - 1));
        pkt_word = word_with_bit;
        pkt_push = in_accept && (is_zero || is_one) && last_bit;

        bit_count_next   = bit_count_reg;
        packet_bits_next = packet_bits_reg;
        if (in_accept) begin
            if (!(is_zero || is_one) || last_bit) begin
                bit_count_next   = '0;
                packet_bits_next = '0;
            end else begin
                bit_count_next   = bit_count_reg + 1'b1;
                packet_bits_next = word_with_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_count_reg   <= '0;
            packet_bits_reg <= '0;
        end else begin
            bit_count_reg   <= bit_count_next;
            packet_bits_reg <= packet_bits_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ppd_queue.sv
// Two-entry queue of packet words between front and back ends.
`default_nettype none
module ppd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire logic [23:0]    din,
    input  wire logic           pop,
    output logic [23:0]         dout,
    output ppd_pkg::ppd_q_stat_t stat
);

    logic [1:0][23:0] mem_reg;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    // Report fill state and present the head entry
    always_comb begin
        stat.full  = (count_reg == 2'd2);
        stat.empty = (count_reg == 2'd0);
        dout       = mem_reg[rd_ptr_reg];
        do_push    = push && !stat.full;
        do_pop     = pop && !stat.empty;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    // Write storage
    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ppd_back.sv
// Back end: check packet words, search head slots and build results.
`default_nettype none
module ppd_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ppd_pkg::ppd_cfg_t cfg,
    input  wire logic             q_empty,
    input  wire logic [23:0]      q_word,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [23:0]           m_tdata,
    output logic [1:0]            m_tuser
);

    ppd_pkg::ppd_bk_state_t state_reg, state_next;

    logic [23:0]               word_reg;
    logic [ppd_pkg::USED_W-1:0] idx_reg, idx_next;
    logic [ppd_pkg::USED_W-1:0] used_reg, used_next;
    logic [ppd_pkg::NUM_SLOTS-1:0][3:0] slot_head_reg;
    logic [ppd_pkg::NUM_SLOTS-1:0][7:0] slot_buzzer_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 out_status_reg;
    logic [3:0]                 out_head_reg;
    logic [ppd_pkg::SLOT_W-1:0] out_slot_reg;
    logic                       out_new_reg;
    logic [7:0]                 out_buzzer_reg;
    logic [7:0]                 out_dist_reg;

    logic [3:0] id, inv_id, head;
    logic [7:0] val, inv_val, rev_val, shift_sel, new_buzzer;
    logic       check_ok, at_end, hit, found, table_full, out_free, load_out, slot_write;
    logic [ppd_pkg::SLOT_W-1:0] slot;

    // Decode the held packet word
    always_comb begin
        id       = word_reg[3:0];
        inv_id   = word_reg[7:4];
        val      = word_reg[15:8];
        inv_val  = word_reg[23:16];
        check_ok = ((id ^ inv_id) == ppd_pkg::ID_MASK) && ((val ^ inv_val) == ppd_pkg::VAL_MASK);
        head     = ppd_pkg::rev4(inv_id);
        rev_val  = ppd_pkg::rev8(val);
        slot     = idx_reg[ppd_pkg::SLOT_W-1:0];
        at_end   = (idx_reg == used_reg);
        hit      = (slot_head_reg[slot] == head);
        found    = (idx_reg < used_reg);
        table_full = !found && (used_reg == ppd_pkg::USED_W'(ppd_pkg::NUM_SLOTS));
        shift_sel  = cfg.shift[slot];
        new_buzzer = {cfg.line_id, 2'b00} + ppd_pkg::BUZZER_BIAS + {4'b0000, head};
        out_free   = !out_valid_reg || m_tready;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ppd_pkg::BK_IDLE: begin
                if (!q_empty) state_next = ppd_pkg::BK_SEARCH;
            end
            ppd_pkg::BK_SEARCH: begin
                if (!check_ok || at_end || hit) state_next = ppd_pkg::BK_FINISH;
            end
            ppd_pkg::BK_FINISH: begin
                if (out_free) state_next = ppd_pkg::BK_IDLE;
            end
            default: state_next = ppd_pkg::BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        q_pop      = 1'b0;
        load_out   = 1'b0;
        slot_write = 1'b0;
        idx_next   = idx_reg;
        unique case (state_reg)
            ppd_pkg::BK_IDLE: begin
                q_pop    = !q_empty;
                idx_next = '0;
            end
            ppd_pkg::BK_SEARCH: begin
                if (check_ok && !at_end && !hit) idx_next = idx_reg + 1'b1;
            end
            ppd_pkg::BK_FINISH: begin
                load_out   = out_free;
                slot_write = out_free && check_ok && !found && !table_full;
            end
            default: ;
        endcase
        used_next      = slot_write ? used_reg + 1'b1 : used_reg;
        out_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Hold the popped word and the result fields
    always_ff @(posedge aclk) begin
        if (q_pop) word_reg <= q_word;
        if (slot_write) begin
            slot_head_reg[slot]   <= head;
            slot_buzzer_reg[slot] <= new_buzzer;
        end
        if (load_out) begin
            if (!check_ok) begin
                out_status_reg <= ppd_pkg::STATUS_CHECK_FAIL;
                out_head_reg   <= '0;
                out_slot_reg   <= '0;
                out_new_reg    <= 1'b0;
                out_buzzer_reg <= '0;
                out_dist_reg   <= '0;
            end else if (table_full) begin
                out_status_reg <= ppd_pkg::STATUS_TABLE_FULL;
                out_head_reg   <= head;
                out_slot_reg   <= '0;
                out_new_reg    <= 1'b0;
                out_buzzer_reg <= '0;
                out_dist_reg   <= '0;
            end else begin
                out_status_reg <= ppd_pkg::STATUS_OK;
                out_head_reg   <= head;
                out_slot_reg   <= slot;
                out_new_reg    <= !found;
                out_buzzer_reg <= found ? slot_buzzer_reg[slot] : new_buzzer;
                out_dist_reg   <= (rev_val < shift_sel) ? 8'd0 : rev_val - shift_sel;
            end
        end
    end

    // Control state and slot table reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ppd_pkg::BK_IDLE;
            idx_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_dist_reg, out_buzzer_reg, out_new_reg, out_slot_reg,
                       out_head_reg};

endmodule
`default_nettype wire

// File: rtl/parking_sensor_pulse_decoder.sv
// Top level of the parking sensor pulse decoder: config registers and the front/back split.
//
//  Channel  Dir  Beat contents
//  s_       in   tdata: low_width[26:0], high_width[53:27], zero pad [55:54]
//  m_       out  tuser: status[1:0]; tdata: head_number[3:0], slot_index[5:4],
//                new_head[6], buzzer_number[14:7], distance[22:15], zero pad [23]
//  cfg_     in   cfg_index selects line_id(0) or shift_slot0..3(1..4), cfg_data
//
// The front end takes one pulse pair per cycle while the packet queue has room.
// Each packet then passes through the back end in order: a pop, a slot search of
// one slot per cycle over the used slots, and a result load into the output register.
// A stalled result output holds the back end; the two-entry queue keeps pairs flowing.
// aresetn is synchronous, active low, and clears the collector, slot table and config.
`default_nettype none
module parking_sensor_pulse_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // low_width[26:0], high_width[53:27]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // head, slot, new_head, buzzer, distance
    output logic [1:0]       m_tuser,   // status[1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    ppd_pkg::ppd_cfg_t    cfg_reg, cfg_next;
    ppd_pkg::ppd_q_stat_t q_stat;
    logic        in_accept, pkt_push, q_pop;
    logic [23:0] pkt_word, q_word;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full;
    assign in_accept = s_tvalid && s_tready;

    // Decode configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                ppd_pkg::REG_LINE_ID:     cfg_next.line_id  = cfg_data[3:0];
                ppd_pkg::REG_SHIFT_SLOT0: cfg_next.shift[0] = cfg_data;
                ppd_pkg::REG_SHIFT_SLOT1: cfg_next.shift[1] = cfg_data;
                ppd_pkg::REG_SHIFT_SLOT2: cfg_next.shift[2] = cfg_data;
                ppd_pkg::REG_SHIFT_SLOT3: cfg_next.shift[3] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) cfg_reg <= '0;
        else          cfg_reg <= cfg_next;
    end

    ppd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .low_width  (s_tdata[26:0]),
        .high_width (s_tdata[53:27]),
        .pkt_push   (pkt_push),
        .pkt_word   (pkt_word)
    );

    ppd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (pkt_push),
        .din     (pkt_word),
        .pop     (q_pop),
        .dout    (q_word),
        .stat    (q_stat)
    );

    ppd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_stat.empty),
        .q_word   (q_word),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
